[sv/gwsc_pkg.sv]
// Shared constants, types and the pattern compare for the grid word search counter.
package gwsc_pkg;

  localparam int CHAR_W      = 8;
  localparam int PAT_LEN     = 4;
  localparam int PAT_W       = 32;
  localparam int HIST_D      = PAT_LEN - 1;
  localparam int HIST_W      = CHAR_W * HIST_D;
  localparam int ROWS_W      = $clog2(PAT_LEN);
  localparam int PRIME_W     = $clog2(HIST_D + 1);
  localparam int HIT_W       = $clog2(4 * 2 + 1);
  localparam int TOTAL_W     = 24;
  localparam int ROW_LEN_W   = 9;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;
  localparam int REG_IDX_BIT = 2;

  localparam logic [TOTAL_W-1:0]   TOTAL_CEIL    = 24'hFFFFFF;
  localparam logic [PAT_W-1:0]     PATTERN_RESET = 32'h584D4153;
  localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 9'd256;

  typedef enum logic {
    REG_PATTERN = 1'b0,
    REG_ROW_LEN = 1'b1
  } reg_idx_t;

  typedef logic [PAT_LEN-1:0][CHAR_W-1:0] seq_t;

  typedef struct packed {
    logic step;
    logic grid_end;
    logic restart;
  } hist_ctl_t;

  typedef struct packed {
    logic                           primed;
    logic [HIST_W-1:0]              cur;
    logic [HIST_D-1:0][CHAR_W-1:0]  anti;
    logic                           col_ge;
    logic                           anti_ok;
    logic                           row_wrap;
  } hist_view_t;

  // 0, 1 or 2: forward and backward hits of one run (first char in the top byte)
  function automatic logic [1:0] judge(input seq_t seq, input logic [PAT_W-1:0] pat);
    logic fwd;
    logic bwd;
    fwd = 1'b1;
    bwd = 1'b1;
    for (int i = 0; i < PAT_LEN; i++) begin
      if (seq[i] != pat[CHAR_W*(PAT_LEN-1-i) +: CHAR_W]) fwd = 1'b0;
      if (seq[i] != pat[CHAR_W*i +: CHAR_W]) bwd = 1'b0;
    end
    return {1'b0, fwd} + {1'b0, bwd};
  endfunction

endpackage

[sv/gwsc_ram.sv]
// Generic single write port RAM with registered read, old data on a same-address clash.
module gwsc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/gwsc_cfg.sv]
// APB register file: pattern characters and row length, with the effective row length.
module gwsc_cfg #(
  parameter int MAX_ROW_LENGTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gwsc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [gwsc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [gwsc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [gwsc_pkg::PAT_W-1:0]        pattern,
  output logic [$clog2(MAX_ROW_LENGTH+1)-1:0] len_eff,
  output logic                              len_write
);
  import gwsc_pkg::*;

  localparam int LW   = $clog2(MAX_ROW_LENGTH + 1);
  localparam int CMPW = (LW > ROW_LEN_W) ? LW : ROW_LEN_W;

  logic [ROW_LEN_W-1:0] row_length;
  logic [CMPW-1:0]      rl_x;
  logic                 wr;
  reg_idx_t             idx;

  assign pready    = 1'b1;
  assign idx       = reg_idx_t'(paddr[REG_IDX_BIT]);
  assign wr        = psel && penable && pwrite && pready;
  assign len_write = wr && (idx == REG_ROW_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern    <= PATTERN_RESET;
      row_length <= ROW_LEN_RESET;
    end else if (wr) begin
      case (idx)
        REG_PATTERN: pattern    <= pwdata[PAT_W-1:0];
        REG_ROW_LEN: row_length <= pwdata[ROW_LEN_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PATTERN: prdata = APB_DATA_W'(pattern);
      REG_ROW_LEN: prdata = APB_DATA_W'(row_length);
      default:     prdata = '0;
    endcase
  end

  // zero or oversize lengths fall back to the maximum
  always_comb begin
    rl_x = CMPW'(row_length);
    if (rl_x == '0 || rl_x > CMPW'(MAX_ROW_LENGTH)) begin
      len_eff = LW'(MAX_ROW_LENGTH);
    end else begin
      len_eff = LW'(rl_x);
    end
  end

endmodule

[sv/gwsc_hist.sv]
// Line store of the rows above, with a column lookahead kept current by forwarding.
module gwsc_hist #(
  parameter int MAX_ROW_LENGTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gwsc_pkg::hist_ctl_t                 ctl,
  input  logic [gwsc_pkg::CHAR_W-1:0]         cell_char,
  input  logic [$clog2(MAX_ROW_LENGTH+1)-1:0] len_eff,
  output gwsc_pkg::hist_view_t                view
);
  import gwsc_pkg::*;

  localparam int CW = $clog2(MAX_ROW_LENGTH);
  localparam int LW = $clog2(MAX_ROW_LENGTH + 1);

  typedef enum logic [1:0] {
    ST_PRIME = 2'b01,
    ST_RUN   = 2'b10
  } hist_state_t;

  hist_state_t         state;
  logic [PRIME_W-1:0]  prime_cnt;
  logic [CW-1:0]       col_pos;
  logic [CW-1:0]       col_pos_next;
  logic [CW-1:0]       fetch_col;
  logic [CW-1:0]       fetch_col_next;
  logic [CW-1:0]       la_col [HIST_D];
  logic [HIST_W-1:0]   la_dat [HIST_D];
  logic [HIST_W-1:0]   cur_dat;
  logic                wr_last_v;
  logic [CW-1:0]       wr_last_col;
  logic [HIST_W-1:0]   wr_last_dat;
  logic [HIST_W-1:0]   rdata;
  logic [HIST_W-1:0]   fetched;
  logic [HIST_W-1:0]   wval;
  logic                we;
  logic                shift;
  logic                reprime;

  function automatic logic [CW-1:0] nxt(input logic [CW-1:0] x, input logic [LW-1:0] len);
    logic [LW-1:0] inc;
    inc = LW'(x) + LW'(1);
    return (inc >= len) ? '0 : CW'(inc);
  endfunction

  assign we      = ctl.step;
  assign shift   = ctl.step || (state == ST_PRIME);
  assign reprime = ctl.restart || (ctl.step && ctl.grid_end);
  // column entry moves down one row, new char on top
  assign wval    = {cur_dat[HIST_W-CHAR_W-1:0], cell_char};

  // the word read last cycle misses a write made in that same cycle
  assign fetched = (wr_last_v && wr_last_col == fetch_col) ? wr_last_dat : rdata;

  always_comb begin
    if (ctl.step) begin
      col_pos_next = ctl.grid_end ? '0 : nxt(col_pos, len_eff);
    end else begin
      col_pos_next = col_pos;
    end
    if (rst) begin
      fetch_col_next = '0;
    end else if (reprime) begin
      fetch_col_next = col_pos_next;
    end else if (shift) begin
      fetch_col_next = nxt(fetch_col, len_eff);
    end else begin
      fetch_col_next = fetch_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_PRIME;
      prime_cnt <= '0;
      col_pos   <= '0;
      fetch_col <= '0;
      wr_last_v <= 1'b0;
    end else begin
      col_pos   <= col_pos_next;
      fetch_col <= fetch_col_next;
      wr_last_v <= we;
      if (reprime) begin
        state     <= ST_PRIME;
        prime_cnt <= '0;
      end else begin
        case (state)
          ST_PRIME: begin
            prime_cnt <= prime_cnt + PRIME_W'(1);
            if (prime_cnt == PRIME_W'(HIST_D)) state <= ST_RUN;
          end
          ST_RUN:   ;
          default:  state <= ST_PRIME;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_last_col <= col_pos;
    wr_last_dat <= wval;
    if (shift) begin
      cur_dat <= (we && la_col[0] == col_pos) ? wval : la_dat[0];
      for (int i = 0; i < HIST_D - 1; i++) begin
        la_dat[i] <= (we && la_col[i+1] == col_pos) ? wval : la_dat[i+1];
        la_col[i] <= la_col[i+1];
      end
      la_dat[HIST_D-1] <= (we && fetch_col == col_pos) ? wval : fetched;
      la_col[HIST_D-1] <= fetch_col;
    end
  end

  gwsc_ram #(
    .WIDTH(HIST_W),
    .DEPTH(MAX_ROW_LENGTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(col_pos),
    .wdata(wval),
    .raddr(fetch_col_next),
    .rdata(rdata)
  );

  always_comb begin
    view.primed   = (state == ST_RUN);
    view.cur      = cur_dat;
    for (int k = 0; k < HIST_D; k++) begin
      view.anti[k] = la_dat[k][CHAR_W*k +: CHAR_W];
    end
    view.col_ge   = (col_pos >= CW'(HIST_D));
    view.anti_ok  = ((LW+1)'(col_pos) + (LW+1)'(HIST_D)) < (LW+1)'(len_eff);
    view.row_wrap = (LW'(col_pos) + LW'(1)) >= len_eff;
  end

`ifndef ASSERT_OFF
  a_chain_head: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (la_col[0] == nxt(col_pos, len_eff)))
    else $error("lookahead head is not the column after the current one");

  a_chain_tail: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (fetch_col == nxt(la_col[HIST_D-1], len_eff)))
    else $error("fetch column out of step with the lookahead");

  a_step_primed: assert property (@(posedge clk) disable iff (rst)
    ctl.step |-> (state == ST_RUN))
    else $error("word taken while the lookahead is reloading");
`endif

endmodule

[sv/grid_word_search_counter_top.sv]
// Grid word search counter: counts a four-char pattern in eight directions over a raster grid.
// One cell word per cycle unless stalled; line store read four columns ahead of the cell.
// Latency: the total is presented the cycle after the grid-end word is accepted.
// After reset, after each grid end and after a row_length write, cell_ready is low while
// the lookahead reloads from the line store; the store is never cleared.
// A grid-end word waits while an earlier total is still untaken. Reset is synchronous.
module grid_word_search_counter_top #(
  parameter int MAX_ROW_LENGTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cell_valid,
  output logic                             cell_ready,
  input  logic [gwsc_pkg::CHAR_W-1:0]      cell_char,
  input  logic                             grid_end,
  output logic                             total_valid,
  input  logic                             total_ready,
  output logic [gwsc_pkg::TOTAL_W-1:0]     match_total,
  output logic                             total_saturated,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gwsc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [gwsc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [gwsc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import gwsc_pkg::*;

  localparam int LW = $clog2(MAX_ROW_LENGTH + 1);

  logic [PAT_W-1:0]    pattern;
  logic [LW-1:0]       len_eff;
  logic                len_write;
  hist_ctl_t           hctl;
  hist_view_t          hview;
  logic                step;

  seq_t                window_cells [HIST_D];
  seq_t                colv;
  seq_t                seq_h;
  seq_t                seq_v;
  seq_t                seq_d;
  seq_t                seq_a;
  logic [ROWS_W-1:0]   rows_seen;
  logic                rows_full;
  logic [TOTAL_W-1:0]  running_total;
  logic                overflow_mark;
  logic [HIT_W-1:0]    hits;
  logic [TOTAL_W:0]    sum;
  logic                sat;
  logic [TOTAL_W-1:0]  total_new;
  logic                mark_new;

  gwsc_cfg #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .pattern  (pattern),
    .len_eff  (len_eff),
    .len_write(len_write)
  );

  gwsc_hist #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
  ) u_hist (
    .clk      (clk),
    .rst      (rst),
    .ctl      (hctl),
    .cell_char(cell_char),
    .len_eff  (len_eff),
    .view     (hview)
  );

  assign cell_ready = hview.primed && !(total_valid && grid_end);
  assign step       = cell_valid && cell_ready;
  assign rows_full  = (rows_seen == ROWS_W'(HIST_D));

  always_comb begin
    hctl.step     = step;
    hctl.grid_end = grid_end;
    hctl.restart  = len_write;
  end

  // runs ending at this cell: row, column, back diagonal (window), forward diagonal
  always_comb begin
    colv[0]          = cell_char;
    seq_h[PAT_LEN-1] = cell_char;
    seq_v[PAT_LEN-1] = cell_char;
    seq_d[PAT_LEN-1] = cell_char;
    seq_a[PAT_LEN-1] = cell_char;
    for (int k = 1; k <= HIST_D; k++) begin
      colv[k]            = hview.cur[CHAR_W*(k-1) +: CHAR_W];
      seq_h[PAT_LEN-1-k] = window_cells[k-1][0];
      seq_v[PAT_LEN-1-k] = hview.cur[CHAR_W*(k-1) +: CHAR_W];
      seq_d[PAT_LEN-1-k] = window_cells[k-1][k];
      seq_a[PAT_LEN-1-k] = hview.anti[k-1];
    end
    hits = '0;
    if (hview.col_ge) hits = hits + HIT_W'(judge(seq_h, pattern));
    if (rows_full) hits = hits + HIT_W'(judge(seq_v, pattern));
    if (rows_full && hview.col_ge) hits = hits + HIT_W'(judge(seq_d, pattern));
    if (rows_full && hview.anti_ok) hits = hits + HIT_W'(judge(seq_a, pattern));
    sum       = {1'b0, running_total} + (TOTAL_W+1)'(hits);
    sat       = (sum >= {1'b0, TOTAL_CEIL});
    total_new = sat ? TOTAL_CEIL : sum[TOTAL_W-1:0];
    mark_new  = overflow_mark || sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < HIST_D; k++) window_cells[k] <= '0;
      rows_seen     <= '0;
      running_total <= '0;
      overflow_mark <= 1'b0;
      total_valid   <= 1'b0;
    end else begin
      if (total_valid && total_ready) total_valid <= 1'b0;
      if (step) begin
        if (grid_end) begin
          total_valid   <= 1'b1;
          for (int k = 0; k < HIST_D; k++) window_cells[k] <= '0;
          rows_seen     <= '0;
          running_total <= '0;
          overflow_mark <= 1'b0;
        end else begin
          for (int k = HIST_D - 1; k >= 1; k--) window_cells[k] <= window_cells[k-1];
          window_cells[0] <= colv;
          if (hview.row_wrap && !rows_full) rows_seen <= rows_seen + ROWS_W'(1);
          running_total <= total_new;
          overflow_mark <= mark_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && grid_end) begin
      match_total     <= total_new;
      total_saturated <= mark_new;
    end
  end

`ifndef ASSERT_OFF
  a_sat_out: assert property (@(posedge clk) disable iff (rst)
    (total_valid && total_saturated) |-> (match_total == TOTAL_CEIL))
    else $error("saturated flag without the ceiling total");

  a_sat_run: assert property (@(posedge clk) disable iff (rst)
    overflow_mark |-> (running_total == TOTAL_CEIL))
    else $error("overflow mark set below the ceiling");
`endif

endmodule

[tb/grid_word_search_counter_top_test.sv]
// Self-checking testbench for grid_word_search_counter_top: cell stream in, grid totals out.
`timescale 1ns / 100ps

module grid_word_search_counter_top_test;
  import gwsc_pkg::*;

  localparam int MAX_COLS    = 256;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int END_LIMIT   = 2000;
  localparam int PHASE_WORDS = 250;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              ends_grid;
  } cell_word_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               sat;
  } grid_total_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cell_valid = 1'b0;
  logic                  cell_ready;
  logic [CHAR_W-1:0]     cell_char = '0;
  logic                  grid_end = 1'b0;
  logic                  total_valid;
  logic                  total_ready = 1'b0;
  logic [TOTAL_W-1:0]    match_total;
  logic                  total_saturated;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  grid_word_search_counter_top #(
    .MAX_ROW_LENGTH(MAX_COLS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cell_valid(cell_valid),
    .cell_ready(cell_ready),
    .cell_char(cell_char),
    .grid_end(grid_end),
    .total_valid(total_valid),
    .total_ready(total_ready),
    .match_total(match_total),
    .total_saturated(total_saturated),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cell_word_t  cells_to_send[$];
  grid_total_t totals_due[$];

  int unsigned send_idle_pct = 7;
  int unsigned recv_idle_pct = 59;
  logic        hold_arm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned totals_seen = 0;

  // shadow of the block: registers, line store, window and counters
  logic [31:0]        pattern_cfg = PATTERN_RESET;
  logic [8:0]         row_len_cfg = ROW_LEN_RESET;
  logic [7:0]         line_store [MAX_COLS][3];
  logic [7:0]         win [3][4];
  int unsigned        col_pos = 0;
  int unsigned        rows_seen = 0;
  logic [TOTAL_W-1:0] running_total = '0;
  logic               saturated = 1'b0;

  function automatic int unsigned active_row_length();
    return (row_len_cfg == 0 || row_len_cfg > MAX_COLS) ? MAX_COLS : int'(row_len_cfg);
  endfunction

  // first cell of the run in the top byte, as in the pattern register
  function automatic int unsigned pattern_hits(input logic [31:0] seq);
    logic [31:0] rev;
    rev = {pattern_cfg[7:0], pattern_cfg[15:8], pattern_cfg[23:16], pattern_cfg[31:24]};
    return (seq == pattern_cfg ? 1 : 0) + (seq == rev ? 1 : 0);
  endfunction

  task automatic clear_grid_state();
    int r;
    int k;
    for (r = 0; r < 3; r++)
      for (k = 0; k < 4; k++) win[r][k] = 8'h00;
    col_pos = 0;
    rows_seen = 0;
    running_total = '0;
    saturated = 1'b0;
  endtask

  // runs ending at this cell: horizontal, vertical, main and anti diagonal
  task automatic count_runs_at_cell(input logic [7:0] ch, input logic ends_grid);
    int unsigned len;
    int unsigned c;
    int unsigned hits;
    int          r;
    int          k;
    logic [7:0]  col [4];
    logic [24:0] sum;
    grid_total_t due;
    len = active_row_length();
    c = col_pos;
    hits = 0;
    if (c >= 3) hits += pattern_hits({win[2][0], win[1][0], win[0][0], ch});
    if (rows_seen >= 3) begin
      hits += pattern_hits({line_store[c][2], line_store[c][1], line_store[c][0], ch});
      if (c >= 3) hits += pattern_hits({win[2][3], win[1][2], win[0][1], ch});
      if (c + 3 < len)
        hits += pattern_hits({line_store[c+3][2], line_store[c+2][1], line_store[c+1][0], ch});
    end
    col[0] = ch;
    for (k = 1; k < 4; k++) col[k] = line_store[c][k-1];
    for (r = 2; r >= 1; r--)
      for (k = 0; k < 4; k++) win[r][k] = win[r-1][k];
    for (k = 0; k < 4; k++) win[0][k] = col[k];
    for (k = 0; k < 3; k++) line_store[c][k] = col[k];
    c++;
    if (c >= len) begin
      c = 0;
      if (rows_seen < 3) rows_seen++;
    end
    col_pos = c;
    sum = {1'b0, running_total} + hits;
    if (sum >= TOTAL_CEIL) begin
      sum = TOTAL_CEIL;
      saturated = 1'b1;
    end
    running_total = sum[TOTAL_W-1:0];
    if (ends_grid) begin
      due.total = running_total;
      due.sat = saturated;
      totals_due = {totals_due, due};
      clear_grid_state();
    end
  endtask

  task automatic report_mismatch(input string what, input grid_total_t want,
                                 input logic [TOTAL_W-1:0] got_total, input logic got_sat);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: total %0d %s: expected %0d/%0b, got %0d/%0b", $time, totals_seen, what,
               want.total, want.sat, got_total, got_sat);
  endtask

  // sender: a word stays on the bus until taken
  always @(posedge clk) begin : cell_driver
    cell_word_t w;
    if (rst) begin
      cell_valid <= 1'b0;
      cell_char <= '0;
      grid_end <= 1'b0;
    end else if (!cell_valid || cell_ready) begin
      if (cells_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = cells_to_send[0];
        cells_to_send.delete(0);
        cell_valid <= 1'b1;
        cell_char <= w.ch;
        grid_end <= w.ends_grid;
      end else begin
        cell_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off once armed
  always @(posedge clk) begin : total_sink
    int unsigned hold_left;
    logic        hold_taken;
    if (rst) begin
      total_ready <= 1'b0;
      hold_left = 0;
      hold_taken = 1'b0;
    end else if (hold_left != 0) begin
      total_ready <= 1'b0;
      hold_left--;
    end else if (hold_arm && !hold_taken) begin
      total_ready <= 1'b0;
      hold_left = HOLD_CYCLES;
      hold_taken = 1'b1;
    end else begin
      total_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    grid_total_t want;
    if (!rst) begin
      if (total_valid && total_ready) begin
        if (totals_due.size() == 0) begin
          want = '0;
          report_mismatch("with none due", want, match_total, total_saturated);
        end else begin
          want = totals_due[0];
          totals_due.delete(0);
          if (match_total !== want.total || total_saturated !== want.sat)
            report_mismatch("wrong", want, match_total, total_saturated);
        end
        totals_seen++;
      end
      if (cell_valid && cell_ready) count_runs_at_cell(cell_char, grid_end);
      if ((cell_valid && cell_ready) || (total_valid && total_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [APB_ADDR_W-1:0] addr;
    addr = idx;
    addr = addr << REG_IDX_BIT;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_PATTERN) pattern_cfg = value;
    else row_len_cfg = value[8:0];
    @(negedge clk);
  endtask

  task automatic push_cell(input logic [7:0] ch, input logic ends_grid);
    cell_word_t w;
    w.ch = ch;
    w.ends_grid = ends_grid;
    cells_to_send = {cells_to_send, w};
  endtask

  // mostly pattern characters so that runs match often
  function automatic logic [7:0] grid_char();
    int unsigned sel;
    sel = $urandom_range(3);
    if ($urandom_range(9) < 8) return pattern_cfg[8*sel +: 8];
    return 8'($urandom_range(255));
  endfunction

  // a cell word that yields no total may still be in flight
  task automatic wait_idle();
    while (cells_to_send.size() != 0 || cell_valid || totals_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic pick_config();
    int unsigned pick;
    logic [7:0]  a;
    logic [7:0]  b;
    pick = $urandom_range(9);
    if (pick <= 5) write_reg(REG_ROW_LEN, $urandom_range(8, 1));
    else if (pick <= 7) write_reg(REG_ROW_LEN, $urandom_range(40, 9));
    else if (pick == 8) write_reg(REG_ROW_LEN, $urandom_range(1) ? 0 : MAX_COLS);
    else write_reg(REG_ROW_LEN, $urandom_range(511, 41));
    if ($urandom_range(1)) begin
      a = $urandom_range(255);
      b = $urandom_range(255);
      case ($urandom_range(4))
        0: write_reg(REG_PATTERN, PATTERN_RESET);
        1: write_reg(REG_PATTERN, {a, b, b, a});
        2: write_reg(REG_PATTERN, {a, a, a, a});
        3: write_reg(REG_PATTERN, {a, b, b, b});
        default: write_reg(REG_PATTERN, $urandom());
      endcase
    end
  endtask

  task automatic queue_grid(output int unsigned n);
    int unsigned len;
    int unsigned i;
    len = active_row_length();
    if (len <= 8) n = $urandom_range(8 * len + 3, 1);
    else if (len <= 40) n = $urandom_range(5 * len, 1);
    else n = $urandom_range(60, 1);
    for (i = 1; i <= n; i++) push_cell(grid_char(), i == n);
  endtask

  // three full rows first so the line store holds every column that is read later
  task automatic queue_split_grid();
    int unsigned len;
    int unsigned n;
    int unsigned i;
    wait_idle();
    len = $urandom_range(10, 4);
    write_reg(REG_ROW_LEN, len);
    n = 3 * len + $urandom_range(len - 1, 0);
    for (i = 0; i < n; i++) push_cell(grid_char(), 1'b0);
    wait_idle();
    len = $urandom_range(len - 1, 1);
    write_reg(REG_ROW_LEN, len);
    n = $urandom_range(4 * len, 1);
    for (i = 1; i <= n; i++) push_cell(grid_char(), i == n);
  endtask

  initial begin : stimulus
    string       fwd_back;
    int          i;
    int          phase;
    int unsigned queued;
    int unsigned n;
    int          guard;
    fwd_back = "XMASAMX";
    for (i = 0; i < MAX_COLS; i++) begin
      line_store[i][0] = 8'h00;
      line_store[i][1] = 8'h00;
      line_store[i][2] = 8'h00;
    end
    clear_grid_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset pattern forwards and backwards, byte extremes, grid ends mid-row
    for (i = 0; i < fwd_back.len(); i++) push_cell(fwd_back[i], 1'b0);
    push_cell(8'h00, 1'b0);
    push_cell(8'hFF, 1'b1);
    // one-column grid: vertical runs only, palindrome counts twice
    wait_idle();
    write_reg(REG_PATTERN, 32'h41414141);
    write_reg(REG_ROW_LEN, 1);
    for (i = 1; i <= 5; i++) push_cell(8'h41, i == 5);
    // row length zero reads as the maximum
    wait_idle();
    write_reg(REG_PATTERN, 32'h00000000);
    write_reg(REG_ROW_LEN, 0);
    for (i = 1; i <= 4; i++) push_cell(8'h00, i == 4);
    // upper bits of the row length word are dropped
    wait_idle();
    write_reg(REG_PATTERN, 32'hFFFFFFFF);
    write_reg(REG_ROW_LEN, 32'h00000300);
    for (i = 1; i <= 4; i++) push_cell(8'hFF, i == 4);

    for (phase = 0; phase < 3; phase++) begin
      wait_idle();
      case (phase)
        0: begin send_idle_pct = 7; recv_idle_pct = 59; end
        1: begin send_idle_pct = 59; recv_idle_pct = 7; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      queued = 0;
      while (queued < PHASE_WORDS) begin
        if (queued == 0 || $urandom_range(2) == 0) begin
          wait_idle();
          pick_config();
        end
        queue_grid(n);
        queued += n;
        if (phase == 2 && !hold_arm && queued > 100) begin
          // short grids back to back so totals pile up behind the hold-off
          wait_idle();
          write_reg(REG_ROW_LEN, 3);
          for (i = 0; i < 12; i++) begin
            queue_grid(n);
            queued += n;
          end
          hold_arm = 1'b1;
        end
      end
      queue_split_grid();
    end

    while (cells_to_send.size() != 0 || cell_valid) @(negedge clk);
    for (guard = 0; guard < END_LIMIT && totals_due.size() != 0; guard++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (totals_due.size() != 0) $display("%0d totals never arrived", totals_due.size());
    if (mismatches == 0 && totals_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/gwsc_pkg.sv
sv/gwsc_ram.sv
sv/gwsc_cfg.sv
sv/gwsc_hist.sv
sv/grid_word_search_counter_top.sv
tb/grid_word_search_counter_top_test.sv
